/* rtl/core/ddoi_pkg.sv */
`default_nettype none
package ddoi_pkg;

  // defaults for top-level parameters
  localparam int WINDOW_MAX_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  // field widths
  localparam int CFG_W  = 5;
  localparam int DS_W   = 24;
  localparam int TH_W   = 16;
  localparam int DT_W   = 20;
  localparam int POS_W  = 32;
  localparam int HEAD_W = 16;
  localparam int VEL_W  = 32;

  // sequencer counter, wide enough for the wipe sweep and cordic stages
  localparam int CNT_W = 8;

  // cordic datapath
  localparam int XY_W = 34;
  localparam int Z_W  = 32;
  localparam int CORDIC_MAX_STAGES = 24;
  localparam logic signed [XY_W-1:0] CORDIC_X0 = 34'sh026DD3B6A;

  localparam logic [CFG_W-1:0] WINDOW_LENGTH_RST = 5'd16;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_CLEAR  = 1'b1
  } opcode_t;

  typedef struct packed {
    logic [0:0]              opcode;
    logic signed [DS_W-1:0]  distance_step;
    logic signed [TH_W-1:0]  heading_step;
    logic [DT_W-1:0]         time_step;
  } in_word_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [HEAD_W-1:0]       heading;
    logic signed [VEL_W-1:0] linear_velocity;
    logic signed [VEL_W-1:0] angular_velocity;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic             capture;
    logic             wipe;
    logic             clear_regs;
    logic             win_write;
    logic             sum_read;
    logic             sum_acc;
    logic             cordic_init;
    logic             cordic_step;
    logic             mul_x;
    logic             acc_x;
    logic             mul_y;
    logic             acc_y;
    logic             div_start;
    logic             div_sel_ang;
    logic             take_lin;
    logic             take_ang;
    logic             vel_zero;
    logic             publish;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic             op_clear;
    logic [CFG_W-1:0] len;
    logic             tsum_zero;
    logic             div_done;
  } stat_t;

  // arctangent table, one turn is 2^32
  function automatic logic signed [Z_W-1:0] atan_val(input logic [4:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      5'd0:    v = 32'sh20000000;
      5'd1:    v = 32'sh12E4051E;
      5'd2:    v = 32'sh09FB385B;
      5'd3:    v = 32'sh051111D4;
      5'd4:    v = 32'sh028B0D43;
      5'd5:    v = 32'sh0145D7E1;
      5'd6:    v = 32'sh00A2F61E;
      5'd7:    v = 32'sh00517C55;
      5'd8:    v = 32'sh0028BE53;
      5'd9:    v = 32'sh00145F2F;
      5'd10:   v = 32'sh000A2F98;
      5'd11:   v = 32'sh000517CC;
      5'd12:   v = 32'sh00028BE6;
      5'd13:   v = 32'sh000145F3;
      5'd14:   v = 32'sh0000A2FA;
      5'd15:   v = 32'sh0000517D;
      5'd16:   v = 32'sh000028BE;
      5'd17:   v = 32'sh0000145F;
      5'd18:   v = 32'sh00000A30;
      5'd19:   v = 32'sh00000518;
      5'd20:   v = 32'sh0000028C;
      5'd21:   v = 32'sh00000146;
      5'd22:   v = 32'sh000000A3;
      5'd23:   v = 32'sh00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/ddoi_ifs.sv */
`default_nettype none
interface ddoi_item_if;
  import ddoi_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ddoi_result_if;
  import ddoi_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/ddoi_ram.sv */
`default_nettype none
module ddoi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/core/ddoi_div.sv */
`default_nettype none
module ddoi_div #(
  parameter int NUM_W = 36,
  parameter int DEN_W = 24
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic      [NUM_W-1:0] quo
);

  localparam int SC_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dvs;
  logic [SC_W-1:0]  steps;
  logic             busy;
  logic [DEN_W:0]   sh;
  logic             fits;

  // one restoring step: shift in next numerator bit, try subtract
  always_comb begin
    sh   = {rem, quo[NUM_W-1]};
    fits = (sh >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= SC_W'(NUM_W);
        rem   <= '0;
        dvs   <= den;
        quo   <= num;
      end else if (busy) begin
        rem   <= fits ? DEN_W'(sh - {1'b0, dvs}) : DEN_W'(sh);
        quo   <= {quo[NUM_W-2:0], fits};
        steps <= steps - SC_W'(1);
        if (steps == SC_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/ddoi_datapath.sv */
`default_nettype none
module ddoi_datapath #(
  parameter int WINDOW_MAX = ddoi_pkg::WINDOW_MAX_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire ddoi_pkg::in_word_t          in_data,
  input  wire logic                        cfg_we,
  input  wire logic [ddoi_pkg::CFG_W-1:0]  cfg_wdata,
  input  wire ddoi_pkg::cmd_t              cmd,
  output ddoi_pkg::stat_t                  stat,
  output ddoi_pkg::out_word_t              out_data
);
  import ddoi_pkg::*;

  localparam int AW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int LW    = $clog2(WINDOW_MAX);
  localparam int DSW   = DS_W + LW;
  localparam int ASW   = TH_W + LW;
  localparam int TSW   = DT_W + LW;
  localparam int NUM_W = ASW + 16;
  localparam int RAM_W = DS_W + TH_W + DT_W;
  localparam int PRD_W = DS_W + XY_W;

  logic [CFG_W-1:0] window_length;
  logic [CFG_W-1:0] len_eff;

  logic signed [DS_W-1:0] ds;
  logic signed [TH_W-1:0] dth;
  logic [DT_W-1:0]        dt;
  logic [16:0]            p;

  logic signed [POS_W-1:0] x_acc;
  logic signed [POS_W-1:0] y_acc;
  logic [HEAD_W-1:0]       heading_acc;
  logic signed [DSW-1:0]   distance_sum;
  logic signed [ASW-1:0]   angle_sum;
  logic [TSW-1:0]          time_sum;
  logic [AW-1:0]           window_pointer;
  logic signed [VEL_W-1:0] lin_vel_reg;
  logic signed [VEL_W-1:0] ang_vel_reg;

  logic signed [XY_W-1:0] cx;
  logic signed [XY_W-1:0] cy;
  logic signed [Z_W-1:0]  cz;
  logic signed [XY_W-1:0] cos_v;
  logic signed [XY_W-1:0] sin_v;
  logic signed [PRD_W-1:0] prod;

  logic [AW-1:0]    ram_waddr;
  logic [RAM_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [RAM_W-1:0] ram_rdata;
  logic             ram_we;

  logic [NUM_W-1:0] div_num;
  logic             div_neg;
  logic             div_done;
  logic [NUM_W-1:0] div_quo;
  logic signed [VEL_W-1:0] div_res;

  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  logic signed [PRD_W-1:0] prod_r;
  logic signed [27:0]      step_t;
  logic signed [POS_W+1:0] acc_sum;
  logic signed [POS_W-1:0] acc_sat;
  logic signed [POS_W-1:0] acc_src;
  logic [CNT_W:0]          ptr_e;
  logic [CNT_W:0]          cnt_e;
  logic signed [NUM_W-1:0] num_s;

  // window length register and its effective value
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_LENGTH_RST;
    end else if (cfg_we) begin
      window_length <= cfg_wdata;
    end
  end

  always_comb begin
    len_eff = window_length;
    if (window_length == '0) begin
      len_eff = CFG_W'(1);
    end else if (int'(window_length) > WINDOW_MAX) begin
      len_eff = CFG_W'(WINDOW_MAX);
    end
  end

  // window memory, one word per step
  always_comb begin
    ptr_e     = (CNT_W+1)'(window_pointer);
    cnt_e     = (CNT_W+1)'(cmd.cnt);
    ram_we    = cmd.wipe | cmd.win_write;
    ram_waddr = cmd.wipe ? cmd.cnt[AW-1:0] : window_pointer;
    ram_wdata = cmd.wipe ? '0 : {ds, dth, dt};
    if (ptr_e >= cnt_e) begin
      ram_raddr = AW'(ptr_e - cnt_e);
    end else begin
      ram_raddr = AW'(ptr_e + (CNT_W+1)'(WINDOW_MAX) - cnt_e);
    end
  end

  ddoi_ram #(
    .WIDTH(RAM_W),
    .DEPTH(WINDOW_MAX)
  ) u_win (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // cordic shifts and quadrant mapping
  always_comb begin
    xs = cx >>> cmd.cnt[4:0];
    ys = cy >>> cmd.cnt[4:0];
    case (p[16:15])
      2'd0: begin cos_v = cx; sin_v = cy; end
      2'd1: begin cos_v = -cy; sin_v = cx; end
      2'd2: begin cos_v = -cx; sin_v = -cy; end
      default: begin cos_v = cy; sin_v = -cx; end
    endcase
  end

  // rounded pose step and saturating add
  always_comb begin
    prod_r  = prod + PRD_W'(64'sd536870912);
    step_t  = prod_r[PRD_W-1:30];
    acc_src = cmd.acc_y ? y_acc : x_acc;
    acc_sum = (POS_W+2)'(acc_src) + (POS_W+2)'(step_t);
    if (acc_sum > (POS_W+2)'(64'sh7FFFFFFF)) begin
      acc_sat = 32'sh7FFFFFFF;
    end else if (acc_sum < -(POS_W+2)'(64'sh80000000)) begin
      acc_sat = 32'sh80000000;
    end else begin
      acc_sat = acc_sum[POS_W-1:0];
    end
  end

  // divider operand: magnitude of the selected numerator
  always_comb begin
    if (cmd.div_sel_ang) begin
      num_s = {angle_sum, 16'h0000};
    end else begin
      num_s = NUM_W'(distance_sum);
    end
    div_num = num_s[NUM_W-1] ? NUM_W'(-num_s) : NUM_W'(num_s);
  end

  ddoi_div #(
    .NUM_W(NUM_W),
    .DEN_W(TSW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (time_sum),
    .done  (div_done),
    .quo   (div_quo)
  );

  // sign and saturate the quotient
  always_comb begin
    if (div_neg) begin
      if (div_quo > NUM_W'(64'h80000000)) begin
        div_res = 32'sh80000000;
      end else begin
        div_res = VEL_W'(-div_quo);
      end
    end else if (div_quo > NUM_W'(64'h7FFFFFFF)) begin
      div_res = 32'sh7FFFFFFF;
    end else begin
      div_res = VEL_W'(div_quo);
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      x_acc          <= '0;
      y_acc          <= '0;
      heading_acc    <= '0;
      distance_sum   <= '0;
      angle_sum      <= '0;
      time_sum       <= '0;
      window_pointer <= '0;
      lin_vel_reg    <= '0;
      ang_vel_reg    <= '0;
    end else begin
      if (cmd.clear_regs) begin
        x_acc          <= '0;
        y_acc          <= '0;
        heading_acc    <= '0;
        distance_sum   <= '0;
        angle_sum      <= '0;
        time_sum       <= '0;
        window_pointer <= '0;
        lin_vel_reg    <= '0;
        ang_vel_reg    <= '0;
      end
      if (cmd.capture) begin
        heading_acc  <= heading_acc + HEAD_W'(in_data.heading_step);
        distance_sum <= DSW'(in_data.distance_step);
        angle_sum    <= ASW'(in_data.heading_step);
        time_sum     <= TSW'(in_data.time_step);
      end
      if (cmd.sum_acc) begin
        distance_sum <= distance_sum + DSW'($signed(ram_rdata[RAM_W-1 -: DS_W]));
        angle_sum    <= angle_sum + ASW'($signed(ram_rdata[DT_W +: TH_W]));
        time_sum     <= time_sum + TSW'(ram_rdata[DT_W-1:0]);
      end
      if (cmd.cordic_init) begin
        if (window_pointer == AW'(WINDOW_MAX - 1)) begin
          window_pointer <= '0;
        end else begin
          window_pointer <= window_pointer + AW'(1);
        end
      end
      if (cmd.acc_x) begin
        x_acc <= acc_sat;
      end
      if (cmd.acc_y) begin
        y_acc <= acc_sat;
      end
      if (cmd.vel_zero) begin
        lin_vel_reg <= '0;
        ang_vel_reg <= '0;
      end
      if (cmd.take_lin && div_done) begin
        lin_vel_reg <= div_res;
      end
      if (cmd.take_ang && div_done) begin
        ang_vel_reg <= div_res;
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ds <= in_data.distance_step;
      dth <= in_data.heading_step;
      dt <= in_data.time_step;
      p  <= {heading_acc, 1'b0} + {in_data.heading_step[TH_W-1], in_data.heading_step};
    end
    if (cmd.cordic_init) begin
      cx <= CORDIC_X0;
      cy <= '0;
      cz <= Z_W'({p[14:0], 15'h0000});
    end
    if (cmd.cordic_step) begin
      if (!cz[Z_W-1]) begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - atan_val(cmd.cnt[4:0]);
      end else begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + atan_val(cmd.cnt[4:0]);
      end
    end
    if (cmd.mul_x) begin
      prod <= PRD_W'(ds) * PRD_W'(cos_v);
    end
    if (cmd.mul_y) begin
      prod <= PRD_W'(ds) * PRD_W'(sin_v);
    end
    if (cmd.div_start) begin
      div_neg <= num_s[NUM_W-1];
    end
    if (cmd.publish) begin
      out_data.pos_x            <= x_acc;
      out_data.pos_y            <= y_acc;
      out_data.heading          <= heading_acc;
      out_data.linear_velocity  <= lin_vel_reg;
      out_data.angular_velocity <= ang_vel_reg;
    end
  end

  always_comb begin
    stat.op_clear  = (in_data.opcode == OP_CLEAR);
    stat.len       = len_eff;
    stat.tsum_zero = (time_sum == '0);
    stat.div_done  = div_done;
  end

endmodule
`default_nettype wire

/* rtl/core/ddoi_ctrl.sv */
`default_nettype none
module ddoi_ctrl #(
  parameter int WINDOW_MAX    = ddoi_pkg::WINDOW_MAX_DEF,
  parameter int CORDIC_STAGES = ddoi_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  output logic                 item_ready,
  input  wire logic            res_ready,
  output logic                 res_valid,
  input  wire ddoi_pkg::stat_t stat,
  output ddoi_pkg::cmd_t       cmd
);
  import ddoi_pkg::*;

  localparam int NST = (CORDIC_STAGES < CORDIC_MAX_STAGES) ? CORDIC_STAGES
                                                           : CORDIC_MAX_STAGES;

  typedef enum logic [3:0] {
    S_WIPE, S_IDLE, S_WRITE, S_SRD, S_SACC, S_CINIT, S_CSTEP,
    S_MULX, S_ACCX, S_MULY, S_ACCY, S_DIVL, S_WAITL, S_DIVA, S_WAITA, S_PUB
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic             pub_after_wipe;
  logic             accept;
  logic             pub_ok;

  always_comb begin
    item_ready = (state == S_IDLE);
    accept     = item_valid && item_ready;
    pub_ok     = !res_valid || res_ready;
  end

  // command decode
  always_comb begin
    cmd             = '0;
    cmd.cnt         = cnt;
    cmd.capture     = accept;
    cmd.wipe        = (state == S_WIPE);
    cmd.clear_regs  = (state == S_WIPE);
    cmd.win_write   = (state == S_WRITE);
    cmd.sum_read    = (state == S_SRD);
    cmd.sum_acc     = (state == S_SACC);
    cmd.cordic_init = (state == S_CINIT);
    cmd.cordic_step = (state == S_CSTEP);
    cmd.mul_x       = (state == S_MULX);
    cmd.acc_x       = (state == S_ACCX);
    cmd.mul_y       = (state == S_MULY);
    cmd.acc_y       = (state == S_ACCY);
    cmd.div_start   = (state == S_DIVL) || (state == S_DIVA);
    cmd.div_sel_ang = (state == S_DIVA);
    cmd.take_lin    = (state == S_WAITL);
    cmd.take_ang    = (state == S_WAITA);
    cmd.vel_zero    = (state == S_ACCY) && stat.tsum_zero;
    cmd.publish     = (state == S_PUB) && pub_ok;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_WIPE;
      cnt            <= '0;
      pub_after_wipe <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_WIPE: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(WINDOW_MAX - 1)) begin
            cnt   <= '0;
            state <= pub_after_wipe ? S_PUB : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cnt <= '0;
            if (stat.op_clear) begin
              pub_after_wipe <= 1'b1;
              state          <= S_WIPE;
            end else begin
              state <= S_WRITE;
            end
          end
        end
        S_WRITE: begin
          cnt   <= CNT_W'(1);
          state <= S_SRD;
        end
        S_SRD: begin
          if (cnt >= CNT_W'(stat.len)) begin
            cnt   <= '0;
            state <= S_CINIT;
          end else begin
            state <= S_SACC;
          end
        end
        S_SACC: begin
          cnt   <= cnt + CNT_W'(1);
          state <= S_SRD;
        end
        S_CINIT: begin
          cnt   <= '0;
          state <= S_CSTEP;
        end
        S_CSTEP: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(NST - 1)) begin
            cnt   <= '0;
            state <= S_MULX;
          end
        end
        S_MULX:  state <= S_ACCX;
        S_ACCX:  state <= S_MULY;
        S_MULY:  state <= S_ACCY;
        S_ACCY:  state <= stat.tsum_zero ? S_PUB : S_DIVL;
        S_DIVL:  state <= S_WAITL;
        S_WAITL: begin
          if (stat.div_done) begin
            state <= S_DIVA;
          end
        end
        S_DIVA:  state <= S_WAITA;
        S_WAITA: begin
          if (stat.div_done) begin
            state <= S_PUB;
          end
        end
        S_PUB: begin
          if (pub_ok) begin
            res_valid      <= 1'b1;
            pub_after_wipe <= 1'b0;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/core/diff_drive_odometry_integrator_core.sv */
`default_nettype none
// channel  | dir | word
// ---------+-----+------------------------------------------------------------
// item     | in  | opcode, distance_step, heading_step, time_step
// result   | out | pos_x, pos_y, heading, linear_velocity, angular_velocity
// cfg      | in  | window_length write (cfg_we, cfg_wdata)
//
// an update word sums the window, runs the cordic, then runs two restoring divides:
// the window sum reads one ram entry at a time, the cordic runs one stage per cycle,
// and the divides run one bit per cycle.
// with a zero time sum the divides are skipped.
// a clear word wipes the window ram, one entry a cycle.
// after reset the window ram is wiped with item.ready low.
// a finished word waits in the output register; the next item is taken meanwhile.
module diff_drive_odometry_integrator_core #(
  parameter int WINDOW_MAX    = ddoi_pkg::WINDOW_MAX_DEF,
  parameter int CORDIC_STAGES = ddoi_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  ddoi_item_if.sink                       item,
  ddoi_result_if.source                   result,
  input  wire logic                       cfg_we,
  input  wire logic [ddoi_pkg::CFG_W-1:0] cfg_wdata
);
  import ddoi_pkg::*;

  cmd_t      cmd;
  stat_t     stat;
  out_word_t out_data;
  logic      item_ready;
  logic      res_valid;

  // sequencer
  ddoi_ctrl #(
    .WINDOW_MAX    (WINDOW_MAX),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item_ready),
    .res_ready  (result.ready),
    .res_valid  (res_valid),
    .stat       (stat),
    .cmd        (cmd)
  );

  // arithmetic and state
  ddoi_datapath #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (item.data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

  assign item.ready   = item_ready;
  assign result.valid = res_valid;
  assign result.data  = out_data;

endmodule
`default_nettype wire
